[rtl/core/ovs_pkg.sv]
`default_nettype none

package ovs_pkg;

   // Field widths of the request and response items
   localparam int DEGREE_W = 3;
   localparam int POS_W    = 18;
   localparam int POS_FRAC = 16;
   localparam int OUT_W    = 32;

   // Coefficient tables are held with this many fraction bits
   localparam int COEF_FRAC = 30;

   // Defaults for the top-level parameters
   localparam int DEFAULT_MAX_DEGREE = 7;
   localparam int DEFAULT_FRAC_BITS  = 16;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_SCALE_F,
      ST_SCALE_D,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Multiplier operations, issued one per cycle and tagged through the product register
   typedef enum logic [2:0] {
      OP_NONE,
      OP_XF,
      OP_BF,
      OP_XD,
      OP_BD,
      OP_CF,
      OP_CD
   } op_type;

   // Recurrence coefficients B[k], Q2.30; the last entry is never reached
   localparam logic signed [63:0] REC_B_Q30 [8] = '{
      64'sd0,
      -64'sd644245094,
      -64'sd777184558,
      -64'sd1458028372,
      -64'sd2341270434,
      -64'sd3156740210,
      -64'sd4280304124,
      64'sd0
   };

   // Per-degree scale factors C[n], Q2.30
   localparam logic signed [63:0] SCALE_Q30 [8] = '{
      64'sd402653184,
      64'sd671088640,
      64'sd927161937,
      64'sd682793674,
      64'sd313139446,
      64'sd106512065,
      64'sd26719237,
      64'sd5368203
   };

   // Round a Q2.30 constant half up to frac fraction bits
   function automatic logic signed [63:0] round_q30(input logic signed [63:0] v,
                                                    input int frac);
      logic signed [63:0] half;
      half = 64'sd1 <<< (COEF_FRAC - 1 - frac);
      round_q30 = (v + half) >>> (COEF_FRAC - frac);
   endfunction

   function automatic logic signed [63:0] rec_b_coef(input logic [DEGREE_W-1:0] idx,
                                                     input int frac);
      rec_b_coef = round_q30(REC_B_Q30[idx], frac);
   endfunction

   function automatic logic signed [63:0] scale_coef(input logic [DEGREE_W-1:0] idx,
                                                     input int frac);
      scale_coef = round_q30(SCALE_Q30[idx], frac);
   endfunction

endpackage

`default_nettype wire

[rtl/core/ovs_mul.sv]
`default_nettype none

module ovs_mul #(
   parameter int A_W = 30,
   parameter int B_W = 19
) (
   input  wire                        clock,
   input  wire logic signed [A_W-1:0] op_a,
   input  wire logic signed [B_W-1:0] op_b,
   output logic signed [A_W+B_W-1:0]  product
);

   logic signed [A_W+B_W-1:0] product_ff;
   logic signed [A_W+B_W-1:0] product_in;

   // Form the full signed product
   assign product_in = op_a * op_b;

   // Register the product before any further use
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

[rtl/core/orthopoly_value_and_slope_top.sv]
`default_nettype none

// Channel    Direction  Ports                                            Transfer
// request    in         req_valid, req_stall, req_degree, req_position  valid & !stall
// response   out        rsp_valid, rsp_stall, rsp_poly_value,
//                       rsp_poly_slope, rsp_saturated                    valid & !stall
//
// One item at a time. Degree 0 answers in the cycle after the transfer; degree d >= 1
// answers once the RUN, SCALE_F, SCALE_D and DRAIN states have passed: four products per
// recurrence step, two for the final scaling and a drain state for the registered multiplier.
// The request side stalls from its transfer until the response has been taken.
// Reset (synchronous, active high) returns the sequencer to idle; no clearing pass.

module orthopoly_value_and_slope_top #(
   parameter int MAX_DEGREE = ovs_pkg::DEFAULT_MAX_DEGREE,
   parameter int FRAC_BITS  = ovs_pkg::DEFAULT_FRAC_BITS
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire logic [ovs_pkg::DEGREE_W-1:0]        req_degree,
   input  wire logic signed [ovs_pkg::POS_W-1:0]    req_position,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic signed [ovs_pkg::OUT_W-1:0]         rsp_poly_value,
   output logic signed [ovs_pkg::OUT_W-1:0]         rsp_poly_slope,
   output logic                                     rsp_saturated
);

   // Recurrence registers, multiplier operand, product and accumulator widths
   localparam int RW  = FRAC_BITS + 14;
   localparam int MW  = (FRAC_BITS + 3 > ovs_pkg::POS_W) ? FRAC_BITS + 3 : ovs_pkg::POS_W;
   localparam int PW  = RW + MW;
   localparam int PX  = PW + 1;
   localparam int AW  = FRAC_BITS + 20;
   localparam int DW  = ovs_pkg::DEGREE_W;
   localparam int OW  = ovs_pkg::OUT_W;
   localparam int OSH = 2 * FRAC_BITS - ovs_pkg::POS_FRAC;

   localparam logic [DW-1:0]        DEG_MAX = DW'(MAX_DEGREE);
   localparam logic signed [RW-1:0] ONE_R   = RW'(1) <<< FRAC_BITS;
   localparam logic signed [AW-1:0] LIM_A   = AW'((64'sd1 <<< (FRAC_BITS + 13)) - 64'sd1);
   localparam logic signed [AW-1:0] NLIM_A  = -LIM_A;
   localparam logic signed [PX-1:0] OMAX_X  = PX'(2147483647);
   localparam logic signed [PX-1:0] OMIN_X  = -OMAX_X;
   localparam logic signed [OW-1:0] ONE_O   = OW'(1) <<< ovs_pkg::POS_FRAC;

   // Round half up, then shift right arithmetically
   function automatic logic signed [PX-1:0] rnd(input logic signed [PX-1:0] v, input int s);
      logic signed [PX-1:0] half;
      half = PX'(1) <<< (s - 1);
      rnd = (v + half) >>> s;
   endfunction

   ovs_pkg::state_type state_ff, state_in;
   ovs_pkg::op_type    pend_ff, issue;
   logic [1:0]         phase_ff, phase_in;
   logic [DW-1:0]      step_ff, step_in;

   logic [DW-1:0]             deg_ff, deg_in;
   logic signed [MW-1:0]      x_ff;
   logic signed [RW-1:0]      fa_ff, fb_ff, da_ff, db_ff;
   logic signed [AW-1:0]      acc_t_ff, acc_d_ff;
   logic signed [OW-1:0]      val_ff, slp_ff;
   logic                      sat_ff;
   logic                      accept;

   logic signed [RW-1:0] op_a;
   logic signed [MW-1:0] op_b;
   logic signed [PW-1:0] prod;
   logic signed [PX-1:0] prod_x;
   logic signed [63:0]   bk_full, c_full;

   logic signed [PX-1:0] rnd_x, rnd_f, rnd_o;
   logic signed [AW-1:0] rnd_x_a, rnd_f_a, clip_src;
   logic signed [RW-1:0] clip_res;
   logic                 clip_hit;
   logic signed [OW-1:0] out_res;
   logic                 out_hit;

   assign deg_in = (req_degree > DEG_MAX) ? DEG_MAX : req_degree;
   assign accept = req_valid && !req_stall;

   // Sequencer: next state, multiplier issue and handshake
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      issue     = ovs_pkg::OP_NONE;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ovs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               phase_in = 2'd0;
               step_in  = '0;
               state_in = (deg_in == '0) ? ovs_pkg::ST_DONE : ovs_pkg::ST_RUN;
            end
         end
         ovs_pkg::ST_RUN: begin
            case (phase_ff)
               2'd0:    issue = ovs_pkg::OP_XF;
               2'd1:    issue = ovs_pkg::OP_BF;
               2'd2:    issue = ovs_pkg::OP_XD;
               2'd3:    issue = ovs_pkg::OP_BD;
               default: issue = ovs_pkg::OP_NONE;
            endcase
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (step_ff == deg_ff - DW'(1)) begin
                  state_in = ovs_pkg::ST_SCALE_F;
               end else begin
                  step_in = step_ff + DW'(1);
               end
            end
         end
         ovs_pkg::ST_SCALE_F: begin
            issue    = ovs_pkg::OP_CF;
            state_in = ovs_pkg::ST_SCALE_D;
         end
         ovs_pkg::ST_SCALE_D: begin
            issue    = ovs_pkg::OP_CD;
            state_in = ovs_pkg::ST_DRAIN;
         end
         ovs_pkg::ST_DRAIN: begin
            state_in = ovs_pkg::ST_DONE;
         end
         ovs_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ovs_pkg::ST_IDLE;
            end
         end
         default: state_in = ovs_pkg::ST_IDLE;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ovs_pkg::ST_IDLE;
         pend_ff  <= ovs_pkg::OP_NONE;
         phase_ff <= 2'd0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= issue;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // Select coefficients for the current step and degree
   assign bk_full = ovs_pkg::rec_b_coef(step_ff, FRAC_BITS);
   assign c_full  = ovs_pkg::scale_coef(deg_ff, FRAC_BITS);

   // Steer operands into the shared multiplier
   always_comb begin
      case (issue)
         ovs_pkg::OP_XF: begin
            op_a = fb_ff;
            op_b = x_ff;
         end
         ovs_pkg::OP_BF: begin
            op_a = fa_ff;
            op_b = bk_full[MW-1:0];
         end
         ovs_pkg::OP_XD: begin
            op_a = db_ff;
            op_b = x_ff;
         end
         ovs_pkg::OP_BD: begin
            op_a = da_ff;
            op_b = bk_full[MW-1:0];
         end
         ovs_pkg::OP_CF: begin
            op_a = fb_ff;
            op_b = c_full[MW-1:0];
         end
         ovs_pkg::OP_CD: begin
            op_a = db_ff;
            op_b = c_full[MW-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   ovs_mul #(
      .A_W (RW),
      .B_W (MW)
   ) u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (prod)
   );

   // Round the registered product for each kind of term
   assign prod_x  = PX'(prod);
   assign rnd_x   = rnd(prod_x, ovs_pkg::POS_FRAC);
   assign rnd_f   = rnd(prod_x, FRAC_BITS);
   assign rnd_o   = rnd(prod_x, OSH);
   assign rnd_x_a = rnd_x[AW-1:0];
   assign rnd_f_a = rnd_f[AW-1:0];

   // Clip the finished recurrence term
   assign clip_src = (pend_ff == ovs_pkg::OP_BF) ? (acc_t_ff + rnd_f_a) : (acc_d_ff + rnd_f_a);
   always_comb begin
      clip_hit = 1'b0;
      if (clip_src > LIM_A) begin
         clip_res = LIM_A[RW-1:0];
         clip_hit = 1'b1;
      end else if (clip_src < NLIM_A) begin
         clip_res = NLIM_A[RW-1:0];
         clip_hit = 1'b1;
      end else begin
         clip_res = clip_src[RW-1:0];
      end
   end

   // Clip the scaled result to the output range
   always_comb begin
      out_hit = 1'b0;
      if (rnd_o > OMAX_X) begin
         out_res = OMAX_X[OW-1:0];
         out_hit = 1'b1;
      end else if (rnd_o < OMIN_X) begin
         out_res = OMIN_X[OW-1:0];
         out_hit = 1'b1;
      end else begin
         out_res = rnd_o[OW-1:0];
      end
   end

   // Load the item on transfer, then fold in each product as it leaves the multiplier
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff   <= MW'(req_position);
         deg_ff <= deg_in;
         fa_ff  <= '0;
         fb_ff  <= ONE_R;
         da_ff  <= '0;
         db_ff  <= '0;
         sat_ff <= 1'b0;
         if (deg_in == '0) begin
            val_ff <= ONE_O;
            slp_ff <= '0;
         end
      end else begin
         case (pend_ff)
            ovs_pkg::OP_XF: begin
               acc_t_ff <= rnd_x_a;
            end
            ovs_pkg::OP_BF: begin
               fa_ff    <= fb_ff;
               fb_ff    <= clip_res;
               acc_d_ff <= AW'(fb_ff);
               sat_ff   <= sat_ff | clip_hit;
            end
            ovs_pkg::OP_XD: begin
               acc_d_ff <= acc_d_ff + rnd_x_a;
            end
            ovs_pkg::OP_BD: begin
               da_ff  <= db_ff;
               db_ff  <= clip_res;
               sat_ff <= sat_ff | clip_hit;
            end
            ovs_pkg::OP_CF: begin
               val_ff <= out_res;
               sat_ff <= sat_ff | out_hit;
            end
            ovs_pkg::OP_CD: begin
               slp_ff <= out_res;
               sat_ff <= sat_ff | out_hit;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_poly_value = val_ff;
   assign rsp_poly_slope = slp_ff;
   assign rsp_saturated  = sat_ff;

endmodule

`default_nettype wire
